FILE: hdl/power_to_db_log_approx_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the power-to-decibel unit
// Clocked implication checks with asynchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef POWER_TO_DB_LOG_APPROX_UNIT_ASSERT_SVH
`define POWER_TO_DB_LOG_APPROX_UNIT_ASSERT_SVH

// same-cycle implication
`define P2DB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define P2DB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/p2db_pkg.sv
// ----------------------------------------------------------------------------
// p2db_pkg
// Types, constants and helpers of the power-to-decibel unit.
// ----------------------------------------------------------------------------
package p2db_pkg;

  // input request: power and reference gain
  typedef struct packed {
    logic [31:0] power_value;
    logic [31:0] norm_gain;
  } in_req_t;

  // output request: level in Q8.8 dB and floor flag
  typedef struct packed {
    logic signed [15:0] level_db;
    logic               clamped;
  } out_req_t;

  // pipeline depth, input register to output register
  localparam int unsigned NumStages = 15;

  // cubic log2 coefficients, Q3.28
  localparam logic [28:0]        Coef0 = 29'd330577167;
  localparam logic signed [31:0] Coef1 = -32'sd1105558180;
  localparam logic signed [31:0] Coef2 = 32'sd1616510301;
  localparam logic signed [31:0] Coef3 = -32'sd841267190;

  // 10*log10(2) in Q28
  localparam logic [29:0] DbScale = 30'd808071242;

  // floor register reset, -80 dB in Q8.8
  localparam logic signed [15:0] FloorReset = -16'sd20480;

  // register port
  localparam int unsigned AddrWidth = 3;
  localparam logic [0:0]  RegFloorDb = 1'b0;

  // Q28 times Q0.32 magnitude, rounded half up, back to Q28
  function automatic logic [31:0] round_q28(logic [63:0] prod);
    logic [63:0] s;
    s = prod + 64'h0000_0000_8000_0000;
    return s[63:32];
  endfunction

  // apply sign to a rounded magnitude and add a coefficient
  function automatic logic [31:0] horner_add(logic neg, logic [31:0] r,
                                             logic signed [31:0] coef);
    logic [31:0] s;
    s = neg ? (32'd0 - r) : r;
    return s + coef;
  endfunction

endpackage

FILE: hdl/power_to_db_log_approx_unit.sv
// ----------------------------------------------------------------------------
// power_to_db_log_approx_unit
// Power to decibel converter with a cubic log2 approximation.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one request per accepted item: an unsigned power
//   value and a Q1.31 reference gain. The output channel returns the level in
//   signed Q8.8 dB and a flag that is set when the level was raised to the
//   floor. Both channels use valid/ready.
//   One request can be accepted every cycle while in_ready_o is high. A
//   request passes through the 15 register stages to out_valid_o:
//   the 32x32 product, three normalizing shift stages, three Horner steps of
//   a multiply stage and a round/add stage each, the exponent add, and the
//   two partial products, rounding and floor compare of the dB scaling.
//   When the receiver stalls, each stage holds only while the stage after it
//   is full, so bubbles close up and requests are still taken until the
//   pipeline is full. Nothing is lost or repeated. Reset empties the
//   pipeline and sets the floor to -80 dB. The user must write the floor via
//   the APB port at byte address 0 only while the unit is idle (unchecked).
// ----------------------------------------------------------------------------
`include "power_to_db_log_approx_unit_assert.svh"

module power_to_db_log_approx_unit
  import p2db_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_req_t              in_req_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_req_t             out_req_o,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned Last = NumStages - 1;

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic signed [15:0] floor_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegFloorDb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FloorReset;
    end else if (cfg_wr) begin
      floor_q <= pwdata[15:0];
    end
  end

  // read back
  always_comb begin
    if (paddr[2] == RegFloorDb) begin
      prdata = {{16{floor_q[15]}}, floor_q};
    end else begin
      prdata = 32'd0;
    end
  end

  // --------------------------------------------------------------------------
  // stage valid bits and per-stage enables
  // --------------------------------------------------------------------------
  logic [Last:0] valid_q;
  logic [Last:0] en;

  // a stage loads when it is empty or the next stage loads too
  always_comb begin
    en[Last] = !valid_q[Last] || out_ready_i;
    for (int k = Last - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[Last];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= Last; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // side band carried along the pipeline
  // --------------------------------------------------------------------------
  logic [Last-1:1] zero_q;            // product was zero
  logic [31:0]     f_q [3:7];         // normalized fraction, Q0.32
  logic [5:0]      b_q [3:9];         // index of the leading one

  // --------------------------------------------------------------------------
  // stage 0: power times gain
  // --------------------------------------------------------------------------
  logic [63:0] p0_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p0_q <= {32'd0, in_req_i.power_value} * {32'd0, in_req_i.norm_gain};
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: zero detect and coarse shift by 32
  // --------------------------------------------------------------------------
  logic [63:0] n1_q;
  logic        lz1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      lz1_q     <= (p0_q[63:32] == 32'd0);
      n1_q      <= (p0_q[63:32] == 32'd0) ? {p0_q[31:0], 32'd0} : p0_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: shifts by 16 and 8
  // --------------------------------------------------------------------------
  logic [63:0] n2_d, n2_q, t16;
  logic        s16, s8;
  logic [2:0]  lz2_q;

  always_comb begin
    s16  = (n1_q[63:48] == 16'd0);
    t16  = s16 ? {n1_q[47:0], 16'd0} : n1_q;
    s8   = (t16[63:56] == 8'd0);
    n2_d = s8 ? {t16[55:0], 8'd0} : t16;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      n2_q  <= n2_d;
      lz2_q <= {lz1_q, s16, s8};
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: shifts by 4, 2 and 1; fraction and exponent out
  // --------------------------------------------------------------------------
  logic [63:0] t4, t2, n3;
  logic        s4, s2, s1;

  always_comb begin
    s4 = (n2_q[63:60] == 4'd0);
    t4 = s4 ? {n2_q[59:0], 4'd0} : n2_q;
    s2 = (t4[63:62] == 2'd0);
    t2 = s2 ? {t4[61:0], 2'd0} : t4;
    s1 = !t2[63];
    n3 = s1 ? {t2[62:0], 1'b0} : t2;
  end

  // side band registers: zero flag from stage 1, fraction and exponent from
  // stage 3, then shifted along with their request
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      zero_q[1] <= (p0_q == 64'd0);
    end
    for (int k = 2; k <= Last - 1; k++) begin
      if (en[k]) begin
        zero_q[k] <= zero_q[k-1];
      end
    end
    if (en[3]) begin
      f_q[3] <= n3[63:32];
      b_q[3] <= ~{lz2_q, s4, s2, s1};
    end
    for (int k = 4; k <= 7; k++) begin
      if (en[k]) begin
        f_q[k] <= f_q[k-1];
      end
    end
    for (int k = 4; k <= 9; k++) begin
      if (en[k]) begin
        b_q[k] <= b_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stages 4 and 5: first Horner step
  // --------------------------------------------------------------------------
  logic [63:0] prod4_q;
  logic [31:0] acc5_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      prod4_q <= {35'd0, Coef0} * {32'd0, f_q[3]};
    end
    if (en[5]) begin
      acc5_q <= horner_add(1'b0, round_q28(prod4_q), Coef1);
    end
  end

  // --------------------------------------------------------------------------
  // stages 6 and 7: second Horner step
  // --------------------------------------------------------------------------
  logic [31:0] mag6;
  logic [63:0] prod6_q;
  logic        neg6_q;
  logic [31:0] acc7_q;

  assign mag6 = acc5_q[31] ? (32'd0 - acc5_q) : acc5_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      prod6_q <= {32'd0, mag6} * {32'd0, f_q[5]};
      neg6_q  <= acc5_q[31];
    end
    if (en[7]) begin
      acc7_q <= horner_add(neg6_q, round_q28(prod6_q), Coef2);
    end
  end

  // --------------------------------------------------------------------------
  // stages 8 and 9: third Horner step
  // --------------------------------------------------------------------------
  logic [31:0] mag8;
  logic [63:0] prod8_q;
  logic        neg8_q;
  logic [31:0] acc9_q;

  assign mag8 = acc7_q[31] ? (32'd0 - acc7_q) : acc7_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      prod8_q <= {32'd0, mag8} * {32'd0, f_q[7]};
      neg8_q  <= acc7_q[31];
    end
    if (en[9]) begin
      acc9_q <= horner_add(neg8_q, round_q28(prod8_q), Coef3);
    end
  end

  // --------------------------------------------------------------------------
  // stage 10: add exponent, take magnitude of log2
  // --------------------------------------------------------------------------
  logic [6:0]  exp10;
  logic [35:0] l2_10, abs10;
  logic [33:0] mag10_q;
  logic        neg10_q;

  always_comb begin
    exp10 = {1'b0, b_q[9]} - 7'd30;
    l2_10 = {{4{acc9_q[31]}}, acc9_q} + {exp10[6], exp10, 28'd0};
    abs10 = l2_10[35] ? (36'd0 - l2_10) : l2_10;
  end

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      mag10_q <= abs10[33:0];
      neg10_q <= l2_10[35];
    end
  end

  // --------------------------------------------------------------------------
  // stages 11 and 12: dB scaling in two partial products
  // --------------------------------------------------------------------------
  logic [46:0] pplo11_q, pplo12_q, pphi12_q;
  logic [16:0] maghi11_q;
  logic        neg11_q, neg12_q;

  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      pplo11_q  <= {30'd0, mag10_q[16:0]} * {17'd0, DbScale};
      maghi11_q <= mag10_q[33:17];
      neg11_q   <= neg10_q;
    end
    if (en[12]) begin
      pphi12_q <= {30'd0, maghi11_q} * {17'd0, DbScale};
      pplo12_q <= pplo11_q;
      neg12_q  <= neg11_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 13: sum, round to Q8.8, apply sign
  // --------------------------------------------------------------------------
  logic [64:0] sum13;
  logic [17:0] lvl13_q;

  assign sum13 = {1'b0, pphi12_q, 17'd0} + {18'd0, pplo12_q} + (65'd1 << 47);

  always_ff @(posedge clk_i) begin
    if (en[13]) begin
      lvl13_q <= neg12_q ? (18'd0 - {1'b0, sum13[64:48]}) : {1'b0, sum13[64:48]};
    end
  end

  // --------------------------------------------------------------------------
  // stage 14: floor compare, output register
  // --------------------------------------------------------------------------
  logic [17:0] floor_ext;
  logic        below;
  out_req_t    out_d, out_q;

  always_comb begin
    floor_ext = {{2{floor_q[15]}}, floor_q};
    below     = $signed(lvl13_q) < $signed(floor_ext);
    if (zero_q[Last-1] || below) begin
      out_d.level_db = floor_q;
      out_d.clamped  = 1'b1;
    end else begin
      out_d.level_db = lvl13_q[15:0];
      out_d.clamped  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[Last]) begin
      out_q <= out_d;
    end
  end

  assign out_req_o = out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `P2DB_ASSERT_IMP(a_clamp_is_floor, clk_i, rst_ni,
    out_valid_o && out_req_o.clamped, out_req_o.level_db == floor_q,
    "clamped result differs from floor")
  `P2DB_ASSERT_IMP(a_unclamped_above_floor, clk_i, rst_ni,
    out_valid_o && !out_req_o.clamped, $signed(out_req_o.level_db) >= $signed(floor_q),
    "unclamped result below floor")
  `P2DB_ASSERT_IMP(a_normalized, clk_i, rst_ni,
    valid_q[3] && !zero_q[3], f_q[3][31],
    "fraction not normalized")
  `P2DB_ASSERT_IMP(a_full_stall_blocks, clk_i, rst_ni,
    (&valid_q) && !out_ready_i, !in_ready_o,
    "request taken into a full stalled pipeline")

endmodule
